// ----- design/wmfc_pkg.sv -----
// shared widths and types for the windowed maximum-fitness centre unit
package wmfc_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int COORD_W = 32;
    localparam int FIT_W   = 16;
    localparam int WLEN_W  = 5;
    localparam int SUM_W   = COORD_W + ADDR_W;
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int EST_W   = FIT_W + 2;

    localparam int IN_W  = 2 * COORD_W + FIT_W;
    localparam int OUT_W = 2 * COORD_W + 2 * FIT_W;

    // configuration register indexes
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_MIN_FITNESS   = 1'b1;

    // one stored place, x in the lowest bits
    typedef struct packed {
        logic [FIT_W-1:0]   fitness;
        logic [COORD_W-1:0] y_coord;
        logic [COORD_W-1:0] x_coord;
    } entry_t;

    // one result, center_x in the lowest bits
    typedef struct packed {
        logic [FIT_W-1:0]   estimate;
        logic [FIT_W-1:0]   max_fitness;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] center_x;
    } result_t;

endpackage

// ----- design/windowed_max_fitness_center_unit.sv -----
// top level: windowed maximum-fitness centre with clamped fitness extrapolation
//
// each accepted place (x, y, fitness) is written into a 16-entry window memory at the
// head pointer; the block then reads the window back oldest first, one entry a cycle
// through the single synchronous read port, tracking the highest fitness and the sums
// of x and y over all places carrying it. two restoring dividers, one quotient bit a
// cycle, then form the truncated means. one transaction consists of the write, the
// read of the fill_count window entries, pipeline drain and divider set-up, the
// 36-step serial division and the load of the output register. a new place is taken
// whenever the sequencer is idle, even while the previous result still waits in the
// output register. the user must write window_length and min_fitness through the cfg
// port only while no transaction is in flight; the block does not enforce this. a
// window length of zero counts as one, one above 16 counts as 16, and shrinking a
// full window drops the surplus oldest places at the next transaction. the window
// memory is not cleared: only entries written since reset are ever read
module windowed_max_fitness_center_unit
    import wmfc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration write port
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [FIT_W-1:0] cfg_data,
    // place input
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // x_coord, y_coord, fitness
    // result output
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // center_x, center_y, max_fitness, estimate
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DINIT = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]          state_reg;

    // configuration
    logic [WLEN_W-1:0]   wlen_reg;
    logic [FIT_W-1:0]    min_fit_reg;

    // window bookkeeping
    logic [ADDR_W-1:0]   head_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [ADDR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]   issue_cnt_reg;

    // window memory, one entry per place
    entry_t              mem [DEPTH];
    entry_t              rdata_reg;

    // read pipeline tags
    logic                rv_reg;
    logic                rfirst_reg;
    logic [FILL_W-1:0]   rk_reg;

    // scan accumulators
    logic [FIT_W-1:0]    best_reg;
    logic signed [SUM_W-1:0] sum_x_reg;
    logic signed [SUM_W-1:0] sum_y_reg;
    logic [FILL_W-1:0]   count_reg;
    logic [FIT_W-1:0]    last_fit_reg;
    logic [FIT_W-1:0]    prev_fit_reg;

    // dividers
    logic [SUM_W-1:0]    qx_reg;
    logic [SUM_W-1:0]    qy_reg;
    logic [FILL_W-1:0]   remx_reg;
    logic [FILL_W-1:0]   remy_reg;
    logic                negx_reg;
    logic                negy_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [FIT_W-1:0]    est_reg;

    // output register
    logic                out_valid_reg;
    result_t             out_reg;

    logic                in_accept;
    logic [FILL_W-1:0]   len_eff;
    logic [FILL_W-1:0]   fill_next;
    entry_t              in_entry;

    logic signed [SUM_W-1:0] rx_ext;
    logic signed [SUM_W-1:0] ry_ext;
    logic [FIT_W-1:0]    rfit;

    logic signed [EST_W-1:0] est_raw;
    logic [FIT_W-1:0]    est_next;

    logic [FILL_W:0]     remx_sh;
    logic [FILL_W:0]     remy_sh;
    logic [FILL_W:0]     div_ext;
    logic                qbit_x;
    logic                qbit_y;
    logic [FILL_W-1:0]   remx_next;
    logic [FILL_W-1:0]   remy_next;
    logic [SUM_W-1:0]    mean_x_full;
    logic [SUM_W-1:0]    mean_y_full;
    logic                out_free;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_entry  = entry_t'(s_tdata);
    assign out_free  = !out_valid_reg || m_tready;

    // effective window length, zero as one and above the depth as the depth
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len_eff = FILL_W'(1);
        end
        else if (int'(wlen_reg) > DEPTH)
        begin
            len_eff = FILL_W'(DEPTH);
        end
        else
        begin
            len_eff = FILL_W'(wlen_reg);
        end
    end

    // fill count after appending, saturating at the window length
    always_comb
    begin
        if ((fill_reg + FILL_W'(1)) > len_eff)
        begin
            fill_next = len_eff;
        end
        else
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    // data returning from the memory, sign-extended for the sums
    assign rfit   = rdata_reg.fitness;
    assign rx_ext = SUM_W'($signed(rdata_reg.x_coord));
    assign ry_ext = SUM_W'($signed(rdata_reg.y_coord));

    // extrapolate 2*last - previous, clamp above to maximum then below; one place: last
    assign est_raw = $signed({1'b0, last_fit_reg, 1'b0}) - $signed({2'b00, prev_fit_reg});
    always_comb
    begin
        if (fill_reg == FILL_W'(1))
        begin
            est_next = last_fit_reg;
        end
        else if (est_raw < $signed({2'b00, min_fit_reg}))
        begin
            est_next = min_fit_reg;
        end
        else if (est_raw > $signed({2'b00, best_reg}))
        begin
            est_next = (best_reg < min_fit_reg) ? min_fit_reg : best_reg;
        end
        else
        begin
            est_next = est_raw[FIT_W-1:0];
        end
    end

    // one restoring division step per cycle on each coordinate
    assign div_ext = {1'b0, count_reg};
    assign remx_sh = {remx_reg, qx_reg[SUM_W-1]};
    assign remy_sh = {remy_reg, qy_reg[SUM_W-1]};
    assign qbit_x  = (remx_sh >= div_ext);
    assign qbit_y  = (remy_sh >= div_ext);
    assign remx_next = qbit_x ? FILL_W'(remx_sh - div_ext) : remx_sh[FILL_W-1:0];
    assign remy_next = qbit_y ? FILL_W'(remy_sh - div_ext) : remy_sh[FILL_W-1:0];

    // truncation toward zero: divide magnitudes, restore the sign
    assign mean_x_full = negx_reg ? (-qx_reg) : qx_reg;
    assign mean_y_full = negy_reg ? (-qy_reg) : qy_reg;

    // window memory: write on an accepted transaction, registered read
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mem[head_reg] <= in_entry;
        end
        rdata_reg <= mem[rd_ptr_reg];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg    <= WLEN_W'(16);
            min_fit_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH: wlen_reg    <= cfg_data[WLEN_W-1:0];
                REG_MIN_FITNESS:   min_fit_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            rd_ptr_reg    <= '0;
            issue_cnt_reg <= '0;
            rv_reg        <= 1'b0;
            rfirst_reg    <= 1'b0;
            rk_reg        <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rv_reg     <= (state_reg == ST_SCAN);
            rfirst_reg <= (issue_cnt_reg == '0);
            rk_reg     <= issue_cnt_reg;

            // result register: raised when a result is loaded, dropped once taken
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        head_reg      <= head_reg + ADDR_W'(1);
                        fill_reg      <= fill_next;
                        // oldest valid slot once the new place is in
                        rd_ptr_reg    <= head_reg + ADDR_W'(1) - fill_next[ADDR_W-1:0];
                        issue_cnt_reg <= '0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    rd_ptr_reg    <= rd_ptr_reg + ADDR_W'(1);
                    issue_cnt_reg <= issue_cnt_reg + FILL_W'(1);
                    if (issue_cnt_reg == fill_reg - FILL_W'(1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_DINIT;
                end
                ST_DINIT:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(SUM_W - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // scan accumulators, divider datapath and output payload
    always_ff @(posedge clk)
    begin
        if (rv_reg)
        begin
            // the oldest entry always restarts the running maximum
            if (rfirst_reg || (rfit > best_reg))
            begin
                best_reg  <= rfit;
                sum_x_reg <= rx_ext;
                sum_y_reg <= ry_ext;
                count_reg <= FILL_W'(1);
            end
            else if (rfit == best_reg)
            begin
                sum_x_reg <= sum_x_reg + rx_ext;
                sum_y_reg <= sum_y_reg + ry_ext;
                count_reg <= count_reg + FILL_W'(1);
            end
            if (rk_reg == fill_reg - FILL_W'(1))
            begin
                last_fit_reg <= rfit;
            end
            if (rk_reg == fill_reg - FILL_W'(2))
            begin
                prev_fit_reg <= rfit;
            end
        end

        if (state_reg == ST_DINIT)
        begin
            negx_reg <= sum_x_reg[SUM_W-1];
            negy_reg <= sum_y_reg[SUM_W-1];
            qx_reg   <= sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : SUM_W'(sum_x_reg);
            qy_reg   <= sum_y_reg[SUM_W-1] ? SUM_W'(-sum_y_reg) : SUM_W'(sum_y_reg);
            remx_reg <= '0;
            remy_reg <= '0;
            est_reg  <= est_next;
        end
        else if (state_reg == ST_DIV)
        begin
            qx_reg   <= {qx_reg[SUM_W-2:0], qbit_x};
            qy_reg   <= {qy_reg[SUM_W-2:0], qbit_y};
            remx_reg <= remx_next;
            remy_reg <= remy_next;
        end

        if ((state_reg == ST_DONE) && out_free)
        begin
            out_reg.center_x    <= mean_x_full[COORD_W-1:0];
            out_reg.center_y    <= mean_y_full[COORD_W-1:0];
            out_reg.max_fitness <= best_reg;
            out_reg.estimate    <= est_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_reg);

endmodule

// ----- design/wmfc_checker.sv -----
// port-level checker for the windowed maximum-fitness centre unit, with its bind
module wmfc_checker
    import wmfc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // one place in flight: input closes right after a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still open after a transaction");

    // a result never appears just after a place is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result too early after a transaction");

    // a new result is only raised while the input is closed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while input was open");

endmodule

bind windowed_max_fitness_center_unit wmfc_checker u_wmfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
